// File: rtl/gfpg_pkg.sv
// Package for the gradient fill pixel generator: widths, codes and payload types.
`default_nettype none

package gfpg_pkg;

  // Pixel coordinate width and fraction width of the blend weight.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Register widths.
  localparam int COLOR_W = 32;
  localparam int POS_W   = 14;
  localparam int RAD_W   = 16;
  localparam int MODE_W  = 3;
  localparam int CH_W    = 8;

  // Datapath widths. Offsets are pixel minus origin, or end minus origin.
  localparam int OFF_W  = POS_W + 1;
  localparam int MAG_W  = POS_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int NUM_W  = 2 * SUM_W;
  localparam int DEN_W  = 2 * RAD_W;
  localparam int PRD_W  = 2 * OFF_W;
  localparam int TM_W   = PRD_W - 1;
  localparam int VT_W   = MAG_W + TM_W;
  localparam int L2_W   = NUM_W;
  localparam int PQ_W   = SUM_W;
  localparam int QUO_W  = 2 * FRAC_BITS;
  localparam int ROOT_W = FRAC_BITS;
  localparam int R_W    = ROOT_W + 2;
  localparam int D_W    = FRAC_BITS + 1;

  // The weight that selects the end color alone.
  localparam logic [D_W-1:0] D_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_START,
    CFG_COLOR_END,
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_END_X,
    CFG_END_Y,
    CFG_RADIUS,
    CFG_SHAPE_MODE
  } cfg_idx_e;

  // Shape modes.
  typedef enum logic [MODE_W-1:0] {
    SHAPE_RADIAL,
    SHAPE_DIAMOND,
    SHAPE_SQUARE,
    SHAPE_LIN_ONE,
    SHAPE_LIN_SYM
  } shape_e;

  // Register file contents.
  typedef struct packed {
    logic [COLOR_W-1:0] color_start;
    logic [COLOR_W-1:0] color_end;
    logic [POS_W-1:0]   origin_x;
    logic [POS_W-1:0]   origin_y;
    logic [POS_W-1:0]   end_x;
    logic [POS_W-1:0]   end_y;
    logic [RAD_W-1:0]   radius;
    logic [MODE_W-1:0]  shape_mode;
  } cfg_t;

  // Geometry front end to projection divider.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [VT_W-1:0]       nx;
    logic [VT_W-1:0]       ny;
    logic                  x_neg;
    logic                  y_neg;
    logic                  vx_neg;
    logic                  vx_zero;
    logic                  vy_neg;
    logic                  vy_zero;
    logic                  linear;
    logic                  one_sided;
    logic                  is_zero;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
  } geom_t;

  // Projection stage to fraction unit.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    logic                  is_zero;
  } frac_t;

  // Fraction unit to blender.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [D_W-1:0]        d;
  } blend_t;

  // Finished pixel.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;
    logic [CH_W-1:0]       alpha;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/gfpg_in_if.sv
// Pixel coordinate channel interface.
`default_nettype none

interface gfpg_in_if
  import gfpg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// File: rtl/gfpg_out_if.sv
// Colored pixel channel interface.
`default_nettype none

interface gfpg_out_if
  import gfpg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;
  logic [CH_W-1:0]       alpha;

  modport source (
    output valid, output out_x, output out_y,
    output red, output green, output blue, output alpha,
    input ready
  );
  modport sink (
    input valid, input out_x, input out_y,
    input red, input green, input blue, input alpha,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/gfpg_geom.sv
// Geometry front end: offsets, distances, squares and projection numerators.
`default_nettype none

module gfpg_geom
  import gfpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  cfg_t                  cfg_i,
  output logic                  valid_o,
  output geom_t                 data_o
);

  // Magnitude of a signed offset; offsets never reach the most negative code.
  function automatic logic [MAG_W-1:0] mag(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] n;
    n = -v;
    return v[OFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  logic [4:0] v_q;

  // Stage 1: offsets.
  logic [COORD_BITS-1:0]   s1_px_q, s1_py_q;
  logic signed [OFF_W-1:0] s1_dx_q, s1_dy_q, s1_vx_q, s1_vy_q;
  logic signed [OFF_W-1:0] s1_dx_d, s1_dy_d, s1_vx_d, s1_vy_d;

  // Stage 2: magnitudes and signed dot product terms.
  logic [COORD_BITS-1:0]   s2_px_q, s2_py_q;
  logic [MAG_W-1:0]        s2_ax_q, s2_ay_q, s2_vxm_q, s2_vym_q;
  logic                    s2_vx_neg_q, s2_vy_neg_q;
  logic signed [PRD_W-1:0] s2_tx_q, s2_ty_q;

  // Stage 3: norm selection, squares, dot product.
  logic [COORD_BITS-1:0]   s3_px_q, s3_py_q;
  logic [SUM_W-1:0]        s3_n_q, s3_n_d;
  logic [2*MAG_W-1:0]      s3_ax2_q, s3_ay2_q, s3_vx2_q, s3_vy2_q;
  logic [DEN_W-1:0]        s3_r2_q;
  logic [RAD_W-1:0]        r_eff;
  logic [MAG_W-1:0]        s3_vxm_q, s3_vym_q;
  logic                    s3_vx_neg_q, s3_vy_neg_q;
  logic signed [PRD_W-1:0] s3_t_q;

  // Stage 4: sums and the magnitude of the dot product.
  logic [COORD_BITS-1:0]   s4_px_q, s4_py_q;
  logic [NUM_W-1:0]        s4_n2_q, s4_s_q;
  logic [L2_W-1:0]         s4_l2_q;
  logic [DEN_W-1:0]        s4_r2_q;
  logic [MAG_W-1:0]        s4_vxm_q, s4_vym_q;
  logic                    s4_vx_neg_q, s4_vy_neg_q;
  logic [TM_W-1:0]         s4_tm_q;
  logic                    s4_t_neg_q;
  logic signed [PRD_W-1:0] s3_t_neg;

  // Stage 5: projection numerators and mode selection.
  geom_t s5_q, s5_d;

  always_comb begin
    s1_dx_d = $signed({{(OFF_W-COORD_BITS){1'b0}}, px_i})
              - $signed({cfg_i.origin_x[POS_W-1], cfg_i.origin_x});
    s1_dy_d = $signed({{(OFF_W-COORD_BITS){1'b0}}, py_i})
              - $signed({cfg_i.origin_y[POS_W-1], cfg_i.origin_y});
    s1_vx_d = $signed({cfg_i.end_x[POS_W-1], cfg_i.end_x})
              - $signed({cfg_i.origin_x[POS_W-1], cfg_i.origin_x});
    s1_vy_d = $signed({cfg_i.end_y[POS_W-1], cfg_i.end_y})
              - $signed({cfg_i.origin_y[POS_W-1], cfg_i.origin_y});
  end

  // A zero radius behaves as radius one.
  assign r_eff = (cfg_i.radius == '0) ? RAD_W'(1) : cfg_i.radius;

  // Diamond takes the sum of the magnitudes, the other modes the larger one.
  always_comb begin
    if (cfg_i.shape_mode == SHAPE_DIAMOND) begin
      s3_n_d = {1'b0, s2_ax_q} + {1'b0, s2_ay_q};
    end else begin
      s3_n_d = (s2_ax_q > s2_ay_q) ? {1'b0, s2_ax_q} : {1'b0, s2_ay_q};
    end
  end

  assign s3_t_neg = -s3_t_q;

  // Stage 5 next value: numerator, denominator and flags for the mode.
  always_comb begin
    s5_d           = '0;
    s5_d.px        = s4_px_q;
    s5_d.py        = s4_py_q;
    s5_d.nx        = VT_W'(s4_vxm_q) * VT_W'(s4_tm_q);
    s5_d.ny        = VT_W'(s4_vym_q) * VT_W'(s4_tm_q);
    s5_d.x_neg     = s4_vx_neg_q ^ s4_t_neg_q;
    s5_d.y_neg     = s4_vy_neg_q ^ s4_t_neg_q;
    s5_d.vx_neg    = s4_vx_neg_q;
    s5_d.vx_zero   = (s4_vxm_q == '0);
    s5_d.vy_neg    = s4_vy_neg_q;
    s5_d.vy_zero   = (s4_vym_q == '0);
    s5_d.one_sided = (cfg_i.shape_mode == SHAPE_LIN_ONE);
    case (cfg_i.shape_mode)
      SHAPE_RADIAL: begin
        s5_d.num = s4_s_q;
        s5_d.den = s4_r2_q;
      end
      SHAPE_DIAMOND, SHAPE_SQUARE: begin
        s5_d.num = s4_n2_q;
        s5_d.den = s4_r2_q;
      end
      SHAPE_LIN_ONE, SHAPE_LIN_SYM: begin
        s5_d.den     = DEN_W'(s4_l2_q);
        s5_d.linear  = (s4_l2_q != '0);
        s5_d.is_zero = (s4_l2_q == '0);
      end
      default: begin
        s5_d.is_zero = 1'b1;
      end
    endcase
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_px_q     <= px_i;
      s1_py_q     <= py_i;
      s1_dx_q     <= s1_dx_d;
      s1_dy_q     <= s1_dy_d;
      s1_vx_q     <= s1_vx_d;
      s1_vy_q     <= s1_vy_d;

      s2_px_q     <= s1_px_q;
      s2_py_q     <= s1_py_q;
      s2_ax_q     <= mag(s1_dx_q);
      s2_ay_q     <= mag(s1_dy_q);
      s2_vxm_q    <= mag(s1_vx_q);
      s2_vym_q    <= mag(s1_vy_q);
      s2_vx_neg_q <= s1_vx_q[OFF_W-1];
      s2_vy_neg_q <= s1_vy_q[OFF_W-1];
      s2_tx_q     <= s1_vx_q * s1_dx_q;
      s2_ty_q     <= s1_vy_q * s1_dy_q;

      s3_px_q     <= s2_px_q;
      s3_py_q     <= s2_py_q;
      s3_n_q      <= s3_n_d;
      s3_ax2_q    <= (2*MAG_W)'(s2_ax_q) * (2*MAG_W)'(s2_ax_q);
      s3_ay2_q    <= (2*MAG_W)'(s2_ay_q) * (2*MAG_W)'(s2_ay_q);
      s3_vx2_q    <= (2*MAG_W)'(s2_vxm_q) * (2*MAG_W)'(s2_vxm_q);
      s3_vy2_q    <= (2*MAG_W)'(s2_vym_q) * (2*MAG_W)'(s2_vym_q);
      s3_r2_q     <= DEN_W'(r_eff) * DEN_W'(r_eff);
      s3_vxm_q    <= s2_vxm_q;
      s3_vym_q    <= s2_vym_q;
      s3_vx_neg_q <= s2_vx_neg_q;
      s3_vy_neg_q <= s2_vy_neg_q;
      s3_t_q      <= s2_tx_q + s2_ty_q;

      s4_px_q     <= s3_px_q;
      s4_py_q     <= s3_py_q;
      s4_n2_q     <= NUM_W'(s3_n_q) * NUM_W'(s3_n_q);
      s4_s_q      <= NUM_W'(s3_ax2_q) + NUM_W'(s3_ay2_q);
      s4_l2_q     <= L2_W'(s3_vx2_q) + L2_W'(s3_vy2_q);
      s4_r2_q     <= s3_r2_q;
      s4_vxm_q    <= s3_vxm_q;
      s4_vym_q    <= s3_vym_q;
      s4_vx_neg_q <= s3_vx_neg_q;
      s4_vy_neg_q <= s3_vy_neg_q;
      s4_tm_q     <= s3_t_q[PRD_W-1] ? s3_t_neg[TM_W-1:0] : s3_t_q[TM_W-1:0];
      s4_t_neg_q  <= s3_t_q[PRD_W-1];

      s5_q        <= s5_d;
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = s5_q;

endmodule

`default_nettype wire

// File: rtl/gfpg_proj.sv
// Projection divider: both projected components, one quotient bit per stage.
`default_nettype none

module gfpg_proj
  import gfpg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  geom_t data_i,
  output logic  valid_o,
  output frac_t data_o
);

  typedef struct packed {
    geom_t            g;
    logic [L2_W-1:0]  rx;
    logic [L2_W-1:0]  ry;
    logic [PQ_W-1:0]  qx;
    logic [PQ_W-1:0]  qy;
  } pst_t;

  pst_t             st_q [PQ_W];
  pst_t             st_d [PQ_W];
  logic [PQ_W-1:0]  v_q;
  logic [1:0]       pv_q;

  geom_t            p1_g_q;
  logic [NUM_W-1:0] p1_qx2_q, p1_qy2_q;
  logic             p1_ok_q, p1_ok_d;
  frac_t            p2_q, p2_d;
  pst_t             last;

  // Divider stages: quotient bits from the top, restoring remainder.
  always_comb begin
    pst_t          cur;
    pst_t          nxt;
    logic [L2_W:0] tx;
    logic [L2_W:0] ty;
    logic [L2_W:0] dv;
    logic          gx;
    logic          gy;
    for (int j = 0; j < PQ_W; j++) begin
      if (j == 0) begin
        cur.g  = data_i;
        cur.rx = L2_W'(data_i.nx >> PQ_W);
        cur.ry = L2_W'(data_i.ny >> PQ_W);
        cur.qx = '0;
        cur.qy = '0;
      end else begin
        cur = st_q[j-1];
      end
      dv  = {1'b0, cur.g.den[L2_W-1:0]};
      tx  = {cur.rx, cur.g.nx[PQ_W-1-j]};
      ty  = {cur.ry, cur.g.ny[PQ_W-1-j]};
      gx  = (tx >= dv);
      gy  = (ty >= dv);
      nxt = cur;
      nxt.rx = gx ? L2_W'(tx - dv) : tx[L2_W-1:0];
      nxt.ry = gy ? L2_W'(ty - dv) : ty[L2_W-1:0];
      nxt.qx = {cur.qx[PQ_W-2:0], gx};
      nxt.qy = {cur.qy[PQ_W-2:0], gy};
      st_d[j] = nxt;
    end
  end

  assign last = st_q[PQ_W-1];

  // Sign test of the one-sided mode: each component has the sign of the vector.
  always_comb begin
    logic x_ok;
    logic y_ok;
    x_ok = ((last.qx == '0) == last.g.vx_zero) &&
           ((last.qx == '0) || (last.g.x_neg == last.g.vx_neg));
    y_ok = ((last.qy == '0) == last.g.vy_zero) &&
           ((last.qy == '0) || (last.g.y_neg == last.g.vy_neg));
    p1_ok_d = x_ok && y_ok;
  end

  // Squared length of the projection for linear items.
  always_comb begin
    p2_d         = '0;
    p2_d.px      = p1_g_q.px;
    p2_d.py      = p1_g_q.py;
    p2_d.den     = p1_g_q.den;
    p2_d.num     = p1_g_q.linear ? NUM_W'(p1_qx2_q + p1_qy2_q) : p1_g_q.num;
    p2_d.is_zero = p1_g_q.is_zero
                   || (p1_g_q.linear && p1_g_q.one_sided && !p1_ok_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      pv_q <= '0;
    end else if (en_i) begin
      v_q  <= {v_q[PQ_W-2:0], valid_i};
      pv_q <= {pv_q[0], v_q[PQ_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < PQ_W; j++) begin
        st_q[j] <= st_d[j];
      end
      p1_g_q   <= last.g;
      p1_qx2_q <= NUM_W'(last.qx) * NUM_W'(last.qx);
      p1_qy2_q <= NUM_W'(last.qy) * NUM_W'(last.qy);
      p1_ok_q  <= p1_ok_d;
      p2_q     <= p2_d;
    end
  end

  assign valid_o = pv_q[1];
  assign data_o  = p2_q;

endmodule

`default_nettype wire

// File: rtl/gfpg_frac.sv
// Fraction unit: clamp test, fractional divider and square root stages.
`default_nettype none

module gfpg_frac
  import gfpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  frac_t  data_i,
  output logic   valid_o,
  output blend_t data_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [DEN_W-1:0]      den;
    logic                  is_zero;
    logic                  is_one;
    logic [DEN_W-1:0]      rem;
    logic [QUO_W-1:0]      q;
  } dst_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  is_zero;
    logic                  is_one;
    logic [QUO_W-1:0]      q;
    logic [R_W-1:0]        rem;
    logic [ROOT_W-1:0]     root;
  } sst_t;

  dst_t              f0_q, f0_d;
  dst_t              dv_q [QUO_W];
  dst_t              dv_d [QUO_W];
  sst_t              sq_q [ROOT_W];
  sst_t              sq_d [ROOT_W];
  logic [QUO_W:0]    dvv_q;
  logic [ROOT_W-1:0] sqv_q;
  sst_t              sq_last;

  // Clamp test; the remainder starts as the numerator.
  always_comb begin
    f0_d         = '0;
    f0_d.px      = data_i.px;
    f0_d.py      = data_i.py;
    f0_d.den     = data_i.den;
    f0_d.is_zero = data_i.is_zero;
    f0_d.is_one  = (DEN_W'(data_i.num) >= data_i.den);
    f0_d.rem     = DEN_W'(data_i.num);
  end

  // Divider stages: numerator times two to the quotient width over the denominator.
  always_comb begin
    dst_t           cur;
    logic [DEN_W:0] t;
    logic [DEN_W:0] dv;
    logic           ge;
    for (int j = 0; j < QUO_W; j++) begin
      if (j == 0) begin
        cur = f0_q;
      end else begin
        cur = dv_q[j-1];
      end
      t   = {cur.rem, 1'b0};
      dv  = {1'b0, cur.den};
      ge  = (t >= dv);
      dv_d[j]     = cur;
      dv_d[j].rem = ge ? DEN_W'(t - dv) : t[DEN_W-1:0];
      dv_d[j].q   = {cur.q[QUO_W-2:0], ge};
    end
  end

  // Square root stages: two radicand bits per stage.
  always_comb begin
    sst_t             cur;
    logic [R_W+1:0]   cand;
    logic [R_W+1:0]   trial;
    logic             ge;
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        cur.px      = dv_q[QUO_W-1].px;
        cur.py      = dv_q[QUO_W-1].py;
        cur.is_zero = dv_q[QUO_W-1].is_zero;
        cur.is_one  = dv_q[QUO_W-1].is_one;
        cur.q       = dv_q[QUO_W-1].q;
        cur.rem     = '0;
        cur.root    = '0;
      end else begin
        cur = sq_q[j-1];
      end
      cand  = {cur.rem, cur.q[QUO_W-1 -: 2]};
      trial = (R_W+2)'({cur.root, 2'b01});
      ge    = (cand >= trial);
      sq_d[j]      = cur;
      sq_d[j].rem  = ge ? R_W'(cand - trial) : cand[R_W-1:0];
      sq_d[j].root = {cur.root[ROOT_W-2:0], ge};
      sq_d[j].q    = cur.q << 2;
    end
  end

  assign sq_last = sq_q[ROOT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q <= '0;
      sqv_q <= '0;
    end else if (en_i) begin
      dvv_q <= {dvv_q[QUO_W-1:0], valid_i};
      sqv_q <= {sqv_q[ROOT_W-2:0], dvv_q[QUO_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f0_q <= f0_d;
      for (int j = 0; j < QUO_W; j++) begin
        dv_q[j] <= dv_d[j];
      end
      for (int j = 0; j < ROOT_W; j++) begin
        sq_q[j] <= sq_d[j];
      end
    end
  end

  // Forced zero wins over the clamp, which wins over the root.
  always_comb begin
    data_o.px = sq_last.px;
    data_o.py = sq_last.py;
    if (sq_last.is_zero) begin
      data_o.d = '0;
    end else if (sq_last.is_one) begin
      data_o.d = D_ONE;
    end else begin
      data_o.d = {1'b0, sq_last.root};
    end
  end

  assign valid_o = sqv_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/gfpg_blend.sv
// Color blender: weighted sum of start and end colors per channel, truncated.
`default_nettype none

module gfpg_blend
  import gfpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  blend_t data_i,
  input  cfg_t   cfg_i,
  output logic   valid_o,
  output res_t   data_o
);

  localparam int P_W = CH_W + D_W;

  logic [1:0]            v_q;
  logic [COORD_BITS-1:0] b1_px_q, b1_py_q;
  logic [P_W-1:0]        b1_ps_q [4];
  logic [P_W-1:0]        b1_pe_q [4];
  logic [P_W-1:0]        ps_d [4];
  logic [P_W-1:0]        pe_d [4];
  logic [CH_W-1:0]       ch_d [4];
  res_t                  b2_q;

  // Products of each channel with its weight.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ps_d[k] = P_W'(cfg_i.color_start[CH_W*k +: CH_W]) * P_W'(D_ONE - data_i.d);
      pe_d[k] = P_W'(cfg_i.color_end[CH_W*k +: CH_W]) * P_W'(data_i.d);
    end
  end

  // Sum and drop the fraction bits.
  always_comb begin
    logic [P_W:0] sum;
    for (int k = 0; k < 4; k++) begin
      sum     = {1'b0, b1_ps_q[k]} + {1'b0, b1_pe_q[k]};
      ch_d[k] = sum[FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_px_q    <= data_i.px;
      b1_py_q    <= data_i.py;
      for (int k = 0; k < 4; k++) begin
        b1_ps_q[k] <= ps_d[k];
        b1_pe_q[k] <= pe_d[k];
      end
      b2_q.px    <= b1_px_q;
      b2_q.py    <= b1_py_q;
      b2_q.red   <= ch_d[0];
      b2_q.green <= ch_d[1];
      b2_q.blue  <= ch_d[2];
      b2_q.alpha <= ch_d[3];
    end
  end

  assign valid_o = v_q[1];
  assign data_o  = b2_q;

endmodule

`default_nettype wire

// File: rtl/gradient_fill_pixel_generator.sv
// Gradient fill pixel generator: registers, pipeline and output skid buffer.
//
// Each transaction on in_i carries one pixel coordinate; each transaction on
// out_o returns that coordinate with its RGBA color, in the same order.
// Settings are written through cfg_we_i, cfg_idx_i and cfg_wdata_i while no
// pixel is in flight; an index past the last register is ignored.
// The datapath is a 73-stage pipeline: five geometry stages, fifteen
// projection divider stages plus two, a clamp stage, thirty-two fractional
// divider stages, sixteen square root stages and two blend stages. One pixel
// is accepted in every cycle while the skid buffer is empty.
// The output register and a one-entry skid buffer decouple the two sides:
// while the receiver stalls, input is still taken until the skid buffer fills,
// then the whole pipeline holds without losing or repeating a pixel.
// Reset clears all valid bits and loads the register defaults: black start,
// white end, origin and end point at zero, radius one, radial mode.
`default_nettype none

module gradient_fill_pixel_generator
  import gfpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gfpg_in_if.sink               in_i,
  gfpg_out_if.source            out_o
);

  cfg_t   cfg_q;
  logic   en;
  logic   geom_valid, proj_valid, frac_valid, bl_valid;
  geom_t  geom_data;
  frac_t  proj_data;
  blend_t frac_data;
  res_t   bl_data;
  logic   out_valid_q, out_valid_d;
  logic   sk_valid_q, sk_valid_d;
  res_t   out_q, out_d;
  res_t   sk_q, sk_d;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_start <= '0;
      cfg_q.color_end   <= '1;
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.end_x       <= '0;
      cfg_q.end_y       <= '0;
      cfg_q.radius      <= RAD_W'(1);
      cfg_q.shape_mode  <= SHAPE_RADIAL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_START: cfg_q.color_start <= cfg_wdata_i[COLOR_W-1:0];
        CFG_COLOR_END:   cfg_q.color_end   <= cfg_wdata_i[COLOR_W-1:0];
        CFG_ORIGIN_X:    cfg_q.origin_x    <= cfg_wdata_i[POS_W-1:0];
        CFG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_wdata_i[POS_W-1:0];
        CFG_END_X:       cfg_q.end_x       <= cfg_wdata_i[POS_W-1:0];
        CFG_END_Y:       cfg_q.end_y       <= cfg_wdata_i[POS_W-1:0];
        CFG_RADIUS:      cfg_q.radius      <= cfg_wdata_i[RAD_W-1:0];
        CFG_SHAPE_MODE:  cfg_q.shape_mode  <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves while the skid buffer is empty.
  assign en         = !sk_valid_q;
  assign in_i.ready = en;

  gfpg_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .px_i    (in_i.pixel_x),
    .py_i    (in_i.pixel_y),
    .cfg_i   (cfg_q),
    .valid_o (geom_valid),
    .data_o  (geom_data)
  );

  gfpg_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geom_valid),
    .data_i  (geom_data),
    .valid_o (proj_valid),
    .data_o  (proj_data)
  );

  gfpg_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (proj_valid),
    .data_i  (proj_data),
    .valid_o (frac_valid),
    .data_o  (frac_data)
  );

  gfpg_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (frac_valid),
    .data_i  (frac_data),
    .cfg_i   (cfg_q),
    .valid_o (bl_valid),
    .data_o  (bl_data)
  );

  // Output register and skid buffer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sk_valid_d  = sk_valid_q;
    sk_d        = sk_q;
    if (sk_valid_q) begin
      if (out_o.ready) begin
        out_d      = sk_q;
        sk_valid_d = 1'b0;
      end
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_d = 1'b0;
      end
      if (bl_valid) begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = bl_data;
          out_valid_d = 1'b1;
        end else begin
          sk_d       = bl_data;
          sk_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_x = out_q.px;
  assign out_o.out_y = out_q.py;
  assign out_o.red   = out_q.red;
  assign out_o.green = out_q.green;
  assign out_o.blue  = out_q.blue;
  assign out_o.alpha = out_q.alpha;

endmodule

`default_nettype wire
